@@ rtl/lcsl_pkg.sv @@
// Package for the longest common subsequence length block.
// Holds the item structs, operation codes, sequencer states and memory controls.
// No dependencies.
`default_nettype none

package lcsl_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_FEED   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam int unsigned LCS_OUT_W = 9;
    localparam int unsigned LCS_OUT_MAX = 511;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [LCS_OUT_W-1:0] lcs_length;
        logic                 overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic sym_we;
        logic row_we;
    } mem_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/lcsl_pe.sv @@
// Shared recurrence unit: one DP row entry from its diagonal, left and up neighbors.
// Depends on nothing but its width parameter.
`default_nettype none

module lcsl_pe #(
    parameter int unsigned DW = 9
) (
    input  wire logic [7:0]    first_sym,
    input  wire logic [7:0]    second_sym,
    input  wire logic [DW-1:0] diag,
    input  wire logic [DW-1:0] left,
    input  wire logic [DW-1:0] up,
    output logic      [DW-1:0] val
);

    always_comb
    begin
        if (first_sym == second_sym)
        begin
            val = diag + DW'(1);
        end
        else if (left > up)
        begin
            val = left;
        end
        else
        begin
            val = up;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lcsl_store.sv @@
// Storage for the first string and the DP row, one write and one registered read each cycle.
// Depends on lcsl_pkg for the memory control struct.
`default_nettype none

module lcsl_store
    import lcsl_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256,
    parameter int unsigned AW      = 8,
    parameter int unsigned DW      = 9
) (
    input  wire logic            clk,
    input  wire mem_ctrl_t       ctrl,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire logic [7:0]      wr_sym,
    input  wire logic [DW-1:0]   wr_val,
    input  wire logic [AW-1:0]   rd_addr,
    output logic      [7:0]      rd_sym,
    output logic      [DW-1:0]   rd_up
);

    logic [7:0]    sym_mem [MAX_LEN];
    logic [DW-1:0] row_mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (ctrl.sym_we)
        begin
            sym_mem[wr_addr] <= wr_sym;
        end
        rd_sym <= sym_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.row_we)
        begin
            row_mem[wr_addr] <= wr_val;
        end
        rd_up <= row_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/lcsl_seq.sv @@
// Sequencer: takes items, keeps the fill count and overflow flag, and walks the DP row.
// Depends on lcsl_pkg for item types, operation codes, states and memory controls.
`default_nettype none

module lcsl_seq
    import lcsl_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256,
    parameter int unsigned AW      = 8,
    parameter int unsigned LW      = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire in_item_t      request,
    input  wire logic [LW-1:0] rd_up,
    input  wire logic [LW-1:0] pe_val,
    output logic               busy,
    output mem_ctrl_t          mem_ctrl,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_sym,
    output logic [LW-1:0]      wr_val,
    output logic [AW-1:0]      rd_addr,
    output logic [7:0]         feed_sym,
    output logic [LW-1:0]      diag,
    output logic [LW-1:0]      left,
    output logic               emit,
    output logic [LW-1:0]      len_out,
    output logic               ovf_out
);

    localparam logic [LW-1:0] MAX_LV = LW'(MAX_LEN);

    seq_state_t    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] left_reg, left_next;
    logic [7:0]    sym_reg, sym_next;
    logic [LW-1:0] idx_inc;
    logic [LW-1:0] len_m1;

    assign idx_inc  = idx_reg + LW'(1);
    assign len_m1   = len_reg - LW'(1);
    assign busy     = (state_reg != ST_IDLE);
    assign wr_sym   = request.symbol;
    assign feed_sym = sym_reg;
    assign diag     = diag_reg;
    assign left     = left_reg;
    assign ovf_out  = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        sym_reg  <= sym_next;
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        diag_next  = diag_reg;
        left_next  = left_reg;
        sym_next   = sym_reg;
        mem_ctrl   = '0;
        wr_addr    = len_reg[AW-1:0];
        wr_val     = '0;
        rd_addr    = '0;
        emit       = 1'b0;
        len_out    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (request.operation)
                        OP_APPEND:
                        begin
                            if (len_reg < MAX_LV)
                            begin
                                mem_ctrl.sym_we = 1'b1;
                                mem_ctrl.row_we = 1'b1;
                                len_next        = len_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_FEED:
                        begin
                            if (len_reg != '0)
                            begin
                                sym_next   = request.symbol;
                                idx_next   = '0;
                                diag_next  = '0;
                                left_next  = '0;
                                state_next = ST_FEED;
                            end
                        end
                        OP_FINISH:
                        begin
                            rd_addr    = len_m1[AW-1:0];
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FEED:
            begin
                mem_ctrl.row_we = 1'b1;
                wr_addr         = idx_reg[AW-1:0];
                wr_val          = pe_val;
                diag_next       = rd_up;
                left_next       = pe_val;
                if (idx_inc == len_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[AW-1:0];
                end
            end
            ST_FINISH:
            begin
                emit       = 1'b1;
                len_out    = (len_reg == '0) ? '0 : rd_up;
                len_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/longest_common_subsequence_length.sv @@
// Longest common subsequence length of two byte strings, one DP row entry per cycle.
// An append leaves busy low; a feed keeps busy high while it walks every first-string
// symbol held (up to MAX_LEN), using the single row memory port and recurrence unit.
// A finish is busy for one cycle; its result passes ST_FINISH and the done register to done.
// Reset clears the fill count, overflow flag and sequencer; the row is tracked by the fill count.
// Depends on lcsl_pkg, lcsl_pe, lcsl_store and lcsl_seq; the receiver cannot stall results.
`default_nettype none

module longest_common_subsequence_length
    import lcsl_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_item_t  request,
    output logic           busy,
    output logic           done,
    output out_item_t      response
);

    localparam int unsigned AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW     = $clog2(MAX_LEN + 1);
    localparam int unsigned LEN_XW = (LW > LCS_OUT_W) ? LW : LCS_OUT_W;

    mem_ctrl_t     mem_ctrl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    wr_sym;
    logic [LW-1:0] wr_val;
    logic [7:0]    rd_sym;
    logic [LW-1:0] rd_up;
    logic [7:0]    feed_sym;
    logic [LW-1:0] diag;
    logic [LW-1:0] left;
    logic [LW-1:0] pe_val;
    logic          emit;
    logic [LW-1:0] len_out;
    logic          ovf_out;
    logic [LEN_XW-1:0] len_x;
    logic              done_reg;
    out_item_t         response_reg;

    lcsl_seq #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .LW      (LW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .rd_up    (rd_up),
        .pe_val   (pe_val),
        .busy     (busy),
        .mem_ctrl (mem_ctrl),
        .wr_addr  (wr_addr),
        .wr_sym   (wr_sym),
        .wr_val   (wr_val),
        .rd_addr  (rd_addr),
        .feed_sym (feed_sym),
        .diag     (diag),
        .left     (left),
        .emit     (emit),
        .len_out  (len_out),
        .ovf_out  (ovf_out)
    );

    lcsl_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .DW      (LW)
    ) u_store (
        .clk     (clk),
        .ctrl    (mem_ctrl),
        .wr_addr (wr_addr),
        .wr_sym  (wr_sym),
        .wr_val  (wr_val),
        .rd_addr (rd_addr),
        .rd_sym  (rd_sym),
        .rd_up   (rd_up)
    );

    lcsl_pe #(
        .DW (LW)
    ) u_pe (
        .first_sym  (rd_sym),
        .second_sym (feed_sym),
        .diag       (diag),
        .left       (left),
        .up         (rd_up),
        .val        (pe_val)
    );

    assign len_x = LEN_XW'(len_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            response_reg.lcs_length <= (len_x > LEN_XW'(LCS_OUT_MAX)) ?
                                       LCS_OUT_W'(LCS_OUT_MAX) : len_x[LCS_OUT_W-1:0];
            response_reg.overflow   <= ovf_out;
        end
    end

    assign done     = done_reg;
    assign response = response_reg;

    // A result follows only a cycle in which the sequencer was busy.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // A finish item produces its result through ST_FINISH and the done register after it is taken.
    a_finish_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation == OP_FINISH) |=> ##1 done)
        else $error("finish item did not produce a result on time");

    // Each result strobe lasts a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // The row is only written while walking a feed or on an append taken while idle.
    a_row_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctrl.row_we |-> (busy || (start && request.operation == OP_APPEND)))
        else $error("row memory written outside an append or a feed");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the longest common subsequence length block.
// Predicts each finish result from a row-by-row LCS model and checks it against done/response.
// Depends on lcsl_pkg and longest_common_subsequence_length.
`timescale 1ns / 100ps

module testbench
    import lcsl_pkg::*;
();

    localparam int unsigned ROW_LEN = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 530;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  request;
    logic      busy;
    logic      done;
    out_item_t response;

    logic [7:0] model_store[ROW_LEN];
    int         model_row[ROW_LEN];
    int         model_fill;
    logic       model_overflow;
    out_item_t  pending_lengths[$];

    logic [7:0] seq_alphabet[4];
    int         seq_alphabet_size;
    bit         quiet;

    int items_sent = 0;
    int lengths_checked = 0;
    int overflow_seen = 0;
    int strings_run = 0;
    int error_count = 0;
    int cycle_count = 0;

    longest_common_subsequence_length #(
        .MAX_LEN(ROW_LEN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .response(response)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_model();
        for (int j = 0; j < ROW_LEN; j++)
        begin
            model_store[j] = 8'h00;
            model_row[j] = 0;
        end
        model_fill = 0;
        model_overflow = 1'b0;
    endfunction

    function automatic void predict_lcs(in_item_t item);
        int diag;
        int left;
        int up;
        int val;
        int len;
        out_item_t res;
        case (item.operation)
            OP_APPEND:
            begin
                if (model_fill < ROW_LEN)
                begin
                    model_store[model_fill] = item.symbol;
                    model_row[model_fill] = 0;
                    model_fill++;
                end
                else
                begin
                    model_overflow = 1'b1;
                end
            end
            OP_FEED:
            begin
                diag = 0;
                left = 0;
                for (int j = 0; j < model_fill; j++)
                begin
                    up = model_row[j];
                    if (model_store[j] == item.symbol)
                        val = diag + 1;
                    else
                        val = (left > up) ? left : up;
                    diag = up;
                    model_row[j] = val;
                    left = val;
                end
            end
            OP_FINISH:
            begin
                len = (model_fill > 0) ? model_row[model_fill - 1] : 0;
                if (len > LCS_OUT_MAX)
                    len = LCS_OUT_MAX;
                res.lcs_length = len[LCS_OUT_W-1:0];
                res.overflow = model_overflow;
                pending_lengths = {pending_lengths, res};
                clear_model();
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic idle_gap();
        int roll;
        int gap;
        in_item_t noise;
        if (quiet)
            return;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 50);
        if (gap > 0)
        begin
            noise = in_item_t'(10'($urandom));
            start <= 1'b0;
            request <= noise;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
        in_item_t item;
        item.operation = op;
        item.symbol = sym;
        idle_gap();
        start <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_lcs(item);
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_lengths.size() != 0);
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 99) < 80)
            return seq_alphabet[$urandom_range(0, seq_alphabet_size - 1)];
        return 8'($urandom);
    endfunction

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n === 1'b1)
        begin
            if ($isunknown(done))
            begin
                $error("done is unknown");
                error_count++;
            end
            else if (done)
            begin
                if (pending_lengths.size() == 0)
                begin
                    $error("result with no finish waiting: lcs_length %0d overflow %0d",
                           response.lcs_length, response.overflow);
                    error_count++;
                end
                else
                begin
                    want = pending_lengths.pop_front();
                    lengths_checked++;
                    if (want.overflow)
                        overflow_seen++;
                    if (response.lcs_length !== want.lcs_length)
                    begin
                        $error("lcs_length mismatch: expected %0d, actual %0d",
                               want.lcs_length, response.lcs_length);
                        error_count++;
                    end
                    if (response.overflow !== want.overflow)
                    begin
                        $error("overflow mismatch: expected %0d, actual %0d",
                               want.overflow, response.overflow);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_empty_strings();
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FINISH, 8'h00);
    endtask

    task automatic test_operations_and_extremes();
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_APPEND, 8'h5A);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'h5A);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_FINISH, 8'hFF);
    endtask

    task automatic test_append_after_feed();
        send_item(OP_APPEND, 8'h11);
        send_item(OP_FEED, 8'h11);
        send_item(OP_APPEND, 8'h22);
        send_item(OP_FEED, 8'h22);
        send_item(OP_APPEND, 8'h80);
        send_item(OP_FEED, 8'h7F);
        send_item(OP_FINISH, 8'h00);
    endtask

    task automatic test_full_store();
        logic [7:0] text[ROW_LEN];
        for (int j = 0; j < ROW_LEN; j++)
        begin
            text[j] = 8'($urandom);
            send_item(OP_APPEND, text[j]);
        end
        for (int j = 0; j < ROW_LEN; j++)
            send_item(OP_FEED, text[j]);
        send_item(OP_FINISH, 8'h00);
        strings_run++;
    endtask

    task automatic test_overflow();
        for (int j = 0; j < ROW_LEN + 3; j++)
            send_item(OP_APPEND, 8'($urandom_range(0, 3)));
        for (int j = 0; j < 24; j++)
            send_item(OP_FEED, 8'($urandom_range(0, 3)));
        send_item(OP_FINISH, 8'h00);
        strings_run++;
        wait_drained();
    endtask

    task automatic random_string_pair();
        int roll;
        int n_first;
        int n_second;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            n_first = 0;
        else if (roll < 85)
            n_first = $urandom_range(1, 12);
        else if (roll < 97)
            n_first = $urandom_range(13, 48);
        else
            n_first = $urandom_range(49, ROW_LEN + 4);
        n_second = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        seq_alphabet_size = $urandom_range(1, 4);
        for (int j = 0; j < 4; j++)
            seq_alphabet[j] = 8'($urandom);
        quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 75)
        begin
            for (int j = 0; j < n_first; j++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_UNUSED, 8'($urandom));
                send_item(OP_APPEND, pick_symbol());
            end
            for (int j = 0; j < n_second; j++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_UNUSED, 8'($urandom));
                send_item(OP_FEED, pick_symbol());
            end
            send_item(OP_FINISH, 8'($urandom));
        end
        else
        begin
            for (int j = 0; j < n_first + n_second; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    send_item(OP_APPEND, pick_symbol());
                else if (roll < 90)
                    send_item(OP_FEED, pick_symbol());
                else
                    send_item(OP_UNUSED, 8'($urandom));
            end
            if ($urandom_range(0, 9) != 0)
                send_item(OP_FINISH, 8'($urandom));
        end
        strings_run++;
        if ($urandom_range(0, 9) == 0)
            wait_drained();
    endtask

    task automatic test_random_pairs();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
            random_string_pair();
        quiet = 1'b0;
        send_item(OP_FINISH, 8'h00);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        quiet = 1'b0;
        seq_alphabet_size = 1;
        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_strings();
        test_operations_and_extremes();
        test_append_after_feed();
        wait_drained();
        test_full_store();
        test_overflow();
        test_random_pairs();

        start <= 1'b0;
        waited = 0;
        while (pending_lengths.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_lengths.size() != 0)
        begin
            $error("%0d finish results never arrived", pending_lengths.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d string pairs, including a full store and overflow.",
                 items_sent, strings_run);
        $display("Checked %0d lengths, %0d of them with overflow set.",
                 lengths_checked, overflow_seen);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
